FILE: src/b64dec_pkg.sv
// ----------------------------------------------------------------------------
// b64dec_pkg
// Shared types, character codes and the alphabet lookup for the Base64 decoder
// ----------------------------------------------------------------------------
`default_nettype none

package b64dec_pkg;

   // result kinds carried on the response channel
   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_OK   = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // lookup result: flag for bytes outside the alphabet, plus the 6-bit value
   typedef struct packed {
      logic       bad;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      logic [7:0] t;
      s.bad   = 1'b0;
      s.value = 6'd0;
      t       = 8'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         t = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         t = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30 + 8'd52;
      end else if (c == 8'h2B) begin
         t = 8'd62;
      end else if (c == 8'h2F) begin
         t = 8'd63;
      end else begin
         s.bad = 1'b1;
      end
      s.value = t[5:0];
      return s;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

endpackage

`default_nettype wire

FILE: src/base64_stream_decoder.sv
// a character accepted at an edge is decoded from the input register in the next
//   cycle and its results go into the result register and out on rsp_*; further
//   results of the same transaction follow one per cycle while rsp_ready is high
// throughput: one character per cycle unless it has results and the result
//   register is busy; a transaction with k results (up to four) keeps the single
//   result register until all k are taken; transactions without results pass
// reset: synchronous, clears group count, error flag and all valid flags
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Decodes a Base64 character stream (standard alphabet) into bytes and a
// per-message status result
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder
   import b64dec_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // character input
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_character,
   input  wire logic       req_char_present,
   input  wire logic       req_end_of_message,
   // decoded output
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_data_byte,
   output logic [1:0]      rsp_kind,
   output logic            rsp_last_of_run
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_present_ff;
   logic       in_end_ff;

   // decoder state
   logic [7:0] held_ff [3];
   logic [1:0] count_ff, count_in;
   logic       err_ff, err_in;

   // result register: up to three data bytes then an optional status
   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] pend_byte_ff [3];
   logic [1:0] pend_data_cnt_ff;
   logic [2:0] pend_total_ff;
   logic [1:0] pend_idx_ff, pend_idx_in;
   kind_type   pend_status_ff;

   // decode of the registered character
   sextet_type s0, s1, s2, s3;
   logic       take, pad2, pad3, grp_bad;
   logic [1:0] grp_n;
   logic [1:0] data_cnt;
   logic       has_status;
   logic [2:0] total;
   kind_type   status_kind;
   logic [7:0] b0, b1, b2;
   logic       consume, pend_last, pend_free;

   always_comb begin
      // whitespace and bytes after an error are dropped
      take = in_present_ff && !err_ff && !is_blank(in_char_ff);
      s0   = sextet_of(held_ff[0]);
      s1   = sextet_of(held_ff[1]);
      s2   = sextet_of(held_ff[2]);
      s3   = sextet_of(in_char_ff);
      pad3 = (in_char_ff == CHAR_PAD);
      pad2 = (held_ff[2] == CHAR_PAD);

      // group check: padding decides how many bytes the group gives
      if (pad3 && pad2) begin
         grp_bad = s0.bad || s1.bad;
         grp_n   = 2'd1;
      end else if (pad3) begin
         grp_bad = s0.bad || s1.bad || s2.bad;
         grp_n   = 2'd2;
      end else begin
         grp_bad = s0.bad || s1.bad || s2.bad || s3.bad;
         grp_n   = 2'd3;
      end

      b0 = {s0.value, s1.value[5:4]};
      b1 = {s1.value[3:0], s2.value[5:2]};
      b2 = {s2.value[1:0], s3.value};

      // next state and result count
      count_in = count_ff;
      err_in   = err_ff;
      data_cnt = 2'd0;
      if (take) begin
         if (count_ff != 2'd3) begin
            count_in = count_ff + 2'd1;
         end else begin
            count_in = 2'd0;
            if (grp_bad) begin
               err_in = 1'b1;
            end else begin
               data_cnt = grp_n;
            end
         end
      end

      // end marker closes the message after any data bytes
      has_status  = in_end_ff;
      status_kind = (err_in || count_in != 2'd0) ? KIND_ERR : KIND_OK;
      if (in_end_ff) begin
         count_in = 2'd0;
         err_in   = 1'b0;
      end

      total = {1'b0, data_cnt} + {2'b00, has_status};
   end

   // handshake between the input register and the result register
   always_comb begin
      pend_last = ({1'b0, pend_idx_ff} + 3'd1) == pend_total_ff;
      pend_free = !pend_valid_ff || (pend_last && rsp_ready);
      // items that give no result pass even while results are draining
      consume   = in_valid_ff && ((total == 3'd0) || pend_free);
      req_ready = !in_valid_ff || consume;

      in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !consume);

      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      if (pend_valid_ff && rsp_ready) begin
         if (pend_last) begin
            pend_valid_in = 1'b0;
         end else begin
            pend_idx_in = pend_idx_ff + 2'd1;
         end
      end
      if (consume && total != 3'd0) begin
         pend_valid_in = 1'b1;
         pend_idx_in   = 2'd0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         count_ff      <= 2'd0;
         err_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_idx_ff   <= 2'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         pend_valid_ff <= pend_valid_in;
         pend_idx_ff   <= pend_idx_in;
         if (consume) begin
            count_ff <= count_in;
            err_ff   <= err_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_char_ff    <= req_character;
         in_present_ff <= req_char_present;
         in_end_ff     <= req_end_of_message;
      end
      if (consume && take && count_ff != 2'd3) begin
         held_ff[count_ff] <= in_char_ff;
      end
      if (consume && total != 3'd0) begin
         pend_byte_ff[0]  <= b0;
         pend_byte_ff[1]  <= b1;
         pend_byte_ff[2]  <= b2;
         pend_data_cnt_ff <= data_cnt;
         pend_total_ff    <= total;
         pend_status_ff   <= status_kind;
      end
   end

   // output select: data bytes first, status last
   always_comb begin
      rsp_valid       = pend_valid_ff;
      rsp_last_of_run = pend_last;
      if (pend_idx_ff < pend_data_cnt_ff) begin
         rsp_kind = KIND_DATA;
         case (pend_idx_ff)
            2'd0:    rsp_data_byte = pend_byte_ff[0];
            2'd1:    rsp_data_byte = pend_byte_ff[1];
            default: rsp_data_byte = pend_byte_ff[2];
         endcase
      end else begin
         rsp_kind      = pend_status_ff;
         rsp_data_byte = 8'd0;
      end
   end

   // a held result set is never empty and the index stays inside it
   a_pend_nonempty: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_total_ff != 3'd0 && {1'b0, pend_idx_ff} < pend_total_ff))
      else $error("result register holds an empty or overrun set");

   // a consumed end marker leaves a clean message state
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (consume && in_end_ff) |=> (count_ff == 2'd0 && !err_ff))
      else $error("end marker did not clear decoder state");

   // new results are loaded only when the register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (consume && total != 3'd0) |-> pend_free)
      else $error("result register overwritten before drained");

   // a status result is always the last of its set
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && rsp_kind != KIND_DATA) |-> pend_last)
      else $error("status result not last of its set");

endmodule

`default_nettype wire

FILE: bench/base64_decode_checker.sv
// ----------------------------------------------------------------------------
// base64_decode_checker
// Watches both channels of the Base64 stream decoder, predicts every result of
// each accepted character and compares the response stream against it in order
// ----------------------------------------------------------------------------
`default_nettype none

module base64_decode_checker
   import b64dec_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_character,
   input  wire logic       req_char_present,
   input  wire logic       req_end_of_message,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_data_byte,
   input  wire logic [1:0] rsp_kind,
   input  wire logic       rsp_last_of_run,
   output int              error_count,
   output int              results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data_byte;
      kind_type   kind;
      logic       run_end;
   } decoded_item_type;

   decoded_item_type decoded_fifo[$];

   // predicted decoder state
   logic [7:0] group_chars [3];
   logic [1:0] chars_held;
   logic       msg_failed;

   // bit 6 flags a byte outside the alphabet
   function automatic logic [6:0] char_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= "A" && c <= "Z") v = c - "A";
      else if (c >= "a" && c <= "z") v = c - "a" + 8'd26;
      else if (c >= "0" && c <= "9") v = c - "0" + 8'd52;
      else if (c == "+") v = 8'd62;
      else if (c == "/") v = 8'd63;
      else return {1'b1, 6'd0};
      return {1'b0, v[5:0]};
   endfunction

   task automatic decode_char(input logic [7:0] c, input logic present, input logic closes);
      logic [6:0]       s0, s1, s2, s3;
      logic [7:0]       out_byte [3];
      logic             bad;
      int               count;
      int               start_len;
      decoded_item_type entry;
      start_len = decoded_fifo.size();
      bad = 1'b0;
      count = 0;
      if (present && !msg_failed && c != CHAR_SPACE && c != CHAR_TAB &&
          c != CHAR_CR && c != CHAR_LF) begin
         if (chars_held != 2'd3) begin
            group_chars[chars_held] = c;
            chars_held = chars_held + 2'd1;
         end else begin
            s0 = char_value(group_chars[0]);
            s1 = char_value(group_chars[1]);
            s2 = char_value(group_chars[2]);
            s3 = char_value(c);
            chars_held = 2'd0;
            if (c == CHAR_PAD && group_chars[2] == CHAR_PAD) begin
               bad = s0[6] | s1[6];
               count = 1;
            end else if (c == CHAR_PAD) begin
               bad = s0[6] | s1[6] | s2[6];
               count = 2;
            end else begin
               bad = s0[6] | s1[6] | s2[6] | s3[6];
               count = 3;
            end
            out_byte[0] = {s0[5:0], s1[5:4]};
            out_byte[1] = {s1[3:0], s2[5:2]};
            out_byte[2] = {s2[1:0], s3[5:0]};
            if (bad) begin
               msg_failed = 1'b1;
            end else begin
               for (int i = 0; i < count; i++) begin
                  entry.data_byte = out_byte[i];
                  entry.kind = KIND_DATA;
                  entry.run_end = 1'b0;
                  decoded_fifo.push_back(entry);
               end
            end
         end
      end
      if (closes) begin
         entry.data_byte = 8'd0;
         entry.kind = (msg_failed || chars_held != 2'd0) ? KIND_ERR : KIND_OK;
         entry.run_end = 1'b0;
         decoded_fifo.push_back(entry);
         chars_held = 2'd0;
         msg_failed = 1'b0;
      end
      if (decoded_fifo.size() > start_len) begin
         entry = decoded_fifo.pop_back();
         entry.run_end = 1'b1;
         decoded_fifo.push_back(entry);
      end
   endtask

   always @(posedge clock) begin
      decoded_item_type want;
      if (reset) begin
         decoded_fifo.delete();
         chars_held = 2'd0;
         msg_failed = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_fifo.size() == 0) begin
               $display("%0t: result with nothing expected, data_byte %h kind %0d",
                        $time, rsp_data_byte, rsp_kind);
               $display("%0t: last_of_run %0b", $time, rsp_last_of_run);
               error_count++;
            end else begin
               want = decoded_fifo.pop_front();
               if (rsp_data_byte !== want.data_byte) begin
                  $display("%0t: data_byte expected %h actual %h",
                           $time, want.data_byte, rsp_data_byte);
                  error_count++;
               end
               if (rsp_kind !== want.kind) begin
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_kind);
                  error_count++;
               end
               if (rsp_last_of_run !== want.run_end) begin
                  $display("%0t: last_of_run expected %0b actual %0b",
                           $time, want.run_end, rsp_last_of_run);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            decode_char(req_character, req_char_present, req_end_of_message);
         end
      end
      results_pending = decoded_fifo.size();
   end

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the Base64 stream decoder with directed messages, then random
// messages, noise and broken groups under three idle profiles; a checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import b64dec_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_character = 8'd0;
   logic       req_char_present = 1'b0;
   logic       req_end_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_data_byte;
   logic [1:0] rsp_kind;
   logic       rsp_last_of_run;

   int error_count;
   int results_pending;

   // idle percentages for each side, changed only at a rising edge
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // set by the stimulus to ask the receiver for one long hold-off
   bit hold_armed = 1'b0;
   int items_sent = 0;
   int cycle_count = 0;

   base64_stream_decoder dut (.*);

   base64_decode_checker decode_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // receiver: random back-pressure, plus one long hold-off counted here
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [7:0] b64_symbol(input int idx);
      if (idx < 26) return 8'("A" + idx);
      if (idx < 52) return 8'("a" + idx - 26);
      if (idx < 62) return 8'("0" + idx - 52);
      return (idx == 62) ? 8'("+") : 8'("/");
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 3))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   // one transaction; entered and left at a falling edge, valid left high so a
   // following transaction can go out back to back
   task automatic send_char(input logic [7:0] c, input logic present, input logic closes);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_character = c;
      req_char_present = present;
      req_end_of_message = closes;
      do @(posedge clock); while (!req_ready);
      if (present || closes) items_sent++;
      @(negedge clock);
   endtask

   task automatic send_string(input string s, input bit closes);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], 1'b1, closes && (i == s.len() - 1));
      end
   endtask

   // drain everything, then switch idle profile at a rising edge
   task automatic next_phase(input int sender_pct, input int receiver_pct, input bit long_hold);
      req_valid = 1'b0;
      while (results_pending != 0) @(negedge clock);
      @(posedge clock);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      hold_armed = long_hold;
      @(negedge clock);
   endtask

   // well-formed message with random content, sometimes damaged on purpose
   task automatic random_message();
      logic [7:0] text[$];
      int         groups;
      int         flaw;
      int         pos;
      bit         close_on_char;
      groups = $urandom_range(0, 4);
      flaw = $urandom_range(0, 9);
      close_on_char = $urandom_range(0, 1);
      for (int g = 0; g < groups; g++) begin
         for (int k = 0; k < 4; k++) text.push_back(b64_symbol($urandom_range(0, 63)));
         // padding mostly on the closing group, now and then mid-stream
         if (g == groups - 1 || $urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               1: text[text.size() - 1] = CHAR_PAD;
               2: begin
                  text[text.size() - 1] = CHAR_PAD;
                  text[text.size() - 2] = CHAR_PAD;
               end
               default: ;
            endcase
         end
      end
      if (text.size() != 0) begin
         pos = $urandom_range(0, text.size() - 1);
         case (flaw)
            0: text[pos] = 8'($urandom_range(0, 255));   // any byte, mostly illegal
            1: text[pos] = CHAR_PAD;                     // padding out of place
            2: void'(text.pop_back());                   // group cut short
            default: ;
         endcase
      end
      foreach (text[i]) begin
         if ($urandom_range(0, 11) == 0) send_char(blank_char(), 1'b1, 1'b0);
         send_char(text[i], 1'b1, close_on_char && (i == text.size() - 1));
      end
      // bare end mark, character field random and ignored
      if (!close_on_char || text.size() == 0) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // random bytes and flag combinations, idle transactions included
   task automatic noise_burst();
      repeat ($urandom_range(3, 10)) begin
         send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 3) == 0));
      end
   endtask

   task automatic random_until(input int target);
      while (items_sent < target) begin
         if ($urandom_range(0, 7) == 0) noise_burst();
         else random_message();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // sender seldom idle, receiver mostly stalled
      next_phase(11, 76, 1'b0);

      // empty message: bare end mark only
      send_char(8'h00, 1'b0, 1'b1);
      // double pad closing a message, end mark on the last character
      send_string("TQ==", 1'b1);
      // top of the alphabet, whitespace inside a group
      send_string("+/", 1'b0);
      send_char(CHAR_SPACE, 1'b1, 1'b0);
      send_string("z9", 1'b0);
      // single pad in mid-stream, decoding goes on afterwards
      send_string("Aa0=", 1'b0);
      send_char(CHAR_TAB, 1'b1, 1'b0);
      send_char(CHAR_CR, 1'b1, 1'b0);
      send_char(CHAR_LF, 1'b1, 1'b0);
      // incomplete group at the end; byte on a bare end mark is not used
      send_string("Z", 1'b0);
      send_char(8'hFF, 1'b0, 1'b1);
      // byte above the alphabet spoils its group, error on the end mark
      send_char(8'h80, 1'b1, 1'b0);
      send_string("AAB", 1'b1);
      // padding in the wrong slot
      send_string("A=A=", 1'b1);

      random_until(140);

      // sender mostly idle, receiver seldom stalled
      next_phase(76, 11, 1'b0);
      random_until(275);

      // no idling, with one long receiver hold-off so the block fills up
      next_phase(0, 0, 1'b1);
      random_until(410);

      req_valid = 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
